// ===== rtl/echt_pkg.sv =====
`default_nettype none

package echt_pkg;

    // Field widths fixed by the interface
    localparam int IDX_W    = 14;
    localparam int EVAL_W   = 16;
    localparam int DEPTH_W  = 8;
    localparam int TERM_W   = 10;
    localparam int MATE_W   = 15;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 15;

    localparam int TABLE_ENTRIES_DEF = 16384;
    localparam int ENTRY_LIMIT_DEF   = 1024;

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MATE   = 1'b1;

    localparam logic              ENABLE_RESET = 1'b1;
    localparam logic [MATE_W-1:0] MATE_RESET   = 15'd31754;

    // Operation codes
    localparam logic OP_CORRECT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Blend and bonus arithmetic
    localparam int W_PAWN        = 10347;
    localparam int W_NONPAWN     = 11665;
    localparam int BLEND_SHIFT   = 17;
    localparam int BLEND_BIAS    = 131071;
    localparam int NP_NUM        = 178;
    localparam int NP_SHIFT      = 7;
    localparam int NO_MOVE_SHIFT = 3;
    localparam int BONUS_FRACTION = 4;

    // Truncating divide by ten: (m * DIV10_MUL) >> DIV10_SHIFT, exact for m below 2^24
    localparam int DIV10_SHIFT = 28;
    localparam logic [24:0] DIV10_MUL = 25'd26843546;

    typedef struct packed {
        logic                       op;
        logic signed [EVAL_W-1:0]   raw_eval;
        logic signed [EVAL_W-1:0]   static_eval;
        logic signed [EVAL_W-1:0]   best_value;
        logic [DEPTH_W-1:0]         search_depth;
        logic                       has_best_move;
        logic                       best_is_capture;
    } t_item;

    // One strobe per datapath stage
    typedef struct packed {
        logic mul;
        logic div;
        logic bonus;
        logic gmul;
        logic gdiv;
    } t_step;

    typedef struct packed {
        logic                       update_applied;
        logic signed [TERM_W-1:0]   correction_term;
        logic signed [EVAL_W-1:0]   eval_out;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/echt_ram.sv =====
`default_nettype none

module echt_ram #(
    parameter int DEPTH = 32768,
    parameter int DW    = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]                 o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/echt_calc.sv =====
`default_nettype none

module echt_calc #(
    parameter int ENTRY_LIMIT = 1024
) (
    input  wire logic                                       i_clk,
    input  wire echt_pkg::t_step                            i_step,
    input  wire echt_pkg::t_item                            i_item,
    input  wire logic                                       i_corr_enable,
    input  wire logic [echt_pkg::MATE_W-1:0]                i_mate_bound,
    input  wire logic [$clog2(ENTRY_LIMIT+1):0]             i_pawn_rd,
    input  wire logic [$clog2(ENTRY_LIMIT+1):0]             i_white_rd,
    input  wire logic [$clog2(ENTRY_LIMIT+1):0]             i_black_rd,
    output echt_pkg::t_result                               o_result,
    output logic                                            o_apply,
    output logic [$clog2(ENTRY_LIMIT+1):0]                  o_pawn_new,
    output logic [$clog2(ENTRY_LIMIT+1):0]                  o_white_new,
    output logic [$clog2(ENTRY_LIMIT+1):0]                  o_black_new
);

    import echt_pkg::*;

    localparam int EW      = $clog2(ENTRY_LIMIT + 1) + 1;
    localparam int LW      = $clog2(ENTRY_LIMIT + 1);
    localparam int MW      = EW + 16;
    localparam int TW      = MW - BLEND_SHIFT;
    localparam int DP_W    = 26;
    localparam int Q_W     = 24;
    localparam int P10_W   = Q_W + 25;
    localparam int BLIM    = ENTRY_LIMIT / BONUS_FRACTION;
    localparam int NPMAX   = (BLIM * NP_NUM) / (2 ** NP_SHIFT);
    localparam int BMAG_W  = $clog2(BLIM + 1);
    localparam int NPMAG_W = $clog2(NPMAX + 1);
    localparam int GP_W    = (EW - 1) + NPMAG_W;
    localparam int KL      = GP_W + LW;
    localparam longint RL  = ((longint'(1) << KL) + longint'(ENTRY_LIMIT) - 1)
                             / longint'(ENTRY_LIMIT);
    localparam int RLW     = $clog2(RL + 1);
    localparam int GD_W    = GP_W + RLW;
    localparam int VW      = 18;

    localparam logic signed [MW-1:0] C_WP   = MW'(W_PAWN);
    localparam logic signed [MW-1:0] C_WN   = MW'(W_NONPAWN);
    localparam logic signed [MW-1:0] C_BIAS = MW'(BLEND_BIAS);

    // Stage registers
    logic signed [MW-1:0]      r_pp;
    logic signed [MW-1:0]      r_pn;
    logic signed [DP_W-1:0]    r_dp;
    logic signed [TW-1:0]      r_term;
    logic [Q_W-1:0]            r_q;
    logic                      r_dneg;
    logic [BMAG_W-1:0]         r_bmag;
    logic [NPMAG_W-1:0]        r_npmag;
    logic                      r_bneg;
    logic [GP_W-1:0]           r_gp   [3];
    logic                      r_eneg [3];
    logic signed [NPMAG_W:0]   r_t    [3];

    logic signed [EW-1:0]      ent    [3];
    logic [NPMAG_W-1:0]        mag    [3];
    logic signed [MW-1:0]      pawn_x;
    logic signed [MW-1:0]      npsum_x;
    logic signed [16:0]        diff;
    logic signed [MW-1:0]      cv;
    logic signed [MW-1:0]      bias;
    logic signed [MW-1:0]      cv_b;
    logic [Q_W-1:0]            dmag;
    logic [P10_W-1:0]          p10;
    logic [BMAG_W-1:0]         bmag;
    logic [BMAG_W+7:0]         npp;
    logic signed [NPMAG_W:0]   bval   [3];
    logic signed [EW+1:0]      nsum   [3];
    logic signed [VW-1:0]      v;
    logic signed [VW-1:0]      mb;
    logic signed [EVAL_W-1:0]  clamped;
    logic                      guard;

    assign ent[0] = $signed(i_pawn_rd);
    assign ent[1] = $signed(i_white_rd);
    assign ent[2] = $signed(i_black_rd);

    // Stage one: blend products, or search gain times depth
    assign pawn_x  = MW'(ent[0]);
    assign npsum_x = MW'(ent[1]) + MW'(ent[2]);
    assign diff    = 17'(i_item.best_value) - 17'(i_item.static_eval);

    always_ff @(posedge i_clk) begin
        if (i_step.mul) begin
            r_pp <= pawn_x * C_WP;
            r_pn <= npsum_x * C_WN;
            r_dp <= DP_W'(diff) * $signed({18'd0, i_item.search_depth});
        end
    end

    // Stage two: truncate the blend, divide the gain
    assign cv = r_pp + r_pn;

    always_comb begin
        bias = '0;
        if (cv[MW-1]) begin
            bias = C_BIAS;
        end
    end

    assign cv_b = cv + bias;
    assign dmag = Q_W'(r_dp[DP_W-1] ? -r_dp : r_dp);
    assign p10  = P10_W'(dmag) * P10_W'(DIV10_MUL);

    always_ff @(posedge i_clk) begin
        if (i_step.div) begin
            r_term <= TW'(cv_b >>> BLEND_SHIFT);
            r_dneg <= r_dp[DP_W-1];
            if (i_item.has_best_move) begin
                r_q <= Q_W'(p10 >> DIV10_SHIFT);
            end else begin
                r_q <= dmag >> NO_MOVE_SHIFT;
            end
        end
    end

    // Stage three: clamp the bonus and scale it for the non-pawn tables
    assign bmag = (r_q > Q_W'(BLIM)) ? BMAG_W'(BLIM) : BMAG_W'(r_q);
    assign npp  = (BMAG_W+8)'(bmag) * (BMAG_W+8)'(NP_NUM);

    always_ff @(posedge i_clk) begin
        if (i_step.bonus) begin
            r_bmag  <= bmag;
            r_npmag <= NPMAG_W'(npp >> NP_SHIFT);
            r_bneg  <= r_dneg;
        end
    end

    assign mag[0] = NPMAG_W'(r_bmag);
    assign mag[1] = r_npmag;
    assign mag[2] = r_npmag;

    // Stages four and five: gravity decay, entry times bonus magnitude over the limit
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_step.gmul) begin
                r_gp[i]   <= GP_W'(EW'(ent[i][EW-1] ? -ent[i] : ent[i])) * GP_W'(mag[i]);
                r_eneg[i] <= ent[i][EW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            logic [GD_W-1:0]    prod;
            logic [NPMAG_W-1:0] tmag;
            prod = GD_W'(r_gp[i]) * GD_W'(RL);
            tmag = prod[KL +: NPMAG_W];
            if (i_step.gdiv) begin
                r_t[i] <= r_eneg[i] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bval[i] = r_bneg ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
            nsum[i] = (EW+2)'(ent[i]) + (EW+2)'(bval[i]) - (EW+2)'(r_t[i]);
        end
    end

    assign o_pawn_new  = EW'(nsum[0]);
    assign o_white_new = EW'(nsum[1]);
    assign o_black_new = EW'(nsum[2]);

    // Final clamp inside the mate bound
    assign v  = VW'(i_item.raw_eval) + VW'(r_term);
    assign mb = $signed(VW'(i_mate_bound));

    always_comb begin
        if (v >= mb) begin
            clamped = EVAL_W'(mb - VW'(1));
        end else if (v <= -mb) begin
            clamped = EVAL_W'(VW'(1) - mb);
        end else begin
            clamped = EVAL_W'(v);
        end
    end

    assign guard = !(i_item.has_best_move && i_item.best_is_capture)
                   && ((i_item.best_value > i_item.static_eval) == i_item.has_best_move);

    assign o_apply = (i_item.op == OP_UPDATE) && i_corr_enable && guard;

    always_comb begin
        o_result = '0;
        if (i_item.op == OP_CORRECT) begin
            if (i_corr_enable) begin
                o_result.eval_out        = clamped;
                o_result.correction_term = TERM_W'(r_term);
            end else begin
                o_result.eval_out = i_item.raw_eval;
            end
        end else begin
            o_result.update_applied = o_apply;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/eval_correction_history_table.sv =====
`default_nettype none

// Channel   Dir  Handshake               Contents
// slave     in   i_s_tvalid/o_s_tready   item: tdata fields, opcode in tuser
// master    out  o_m_tvalid/i_m_tready   result: eval, correction term, update flag
// config    in   i_cfg_we                register index and data, no read-back
//
// A correct item passes through memory read, product and divide stages; an update adds
// bonus, gravity multiply and gravity divide stages, then at most one write-back to
// the three tables. No item is taken until the last has left its write-back state.
// After reset a clearing pass writes zero to 2 * TABLE_ENTRIES entries of each table,
// one a cycle, before the first item is taken; config writes are taken throughout.
// A stalled result holds in the output register; the next item is taken while it
// waits, and its write-back waits until the register is free.

module eval_correction_history_table #(
    parameter int TABLE_ENTRIES = echt_pkg::TABLE_ENTRIES_DEF,
    parameter int ENTRY_LIMIT   = echt_pkg::ENTRY_LIMIT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // side, pawn_index, white_np_index, black_np_index, raw_eval, static_eval,
    // best_value, search_depth, has_best_move, best_is_capture, zero fill
    input  wire logic [103:0]                   i_s_tdata,
    // opcode
    input  wire logic [0:0]                     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // eval_out, correction_term, update_applied, zero fill
    output logic [31:0]                         o_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [echt_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [echt_pkg::CFG_DW-1:0]    i_cfg_wdata
);

    import echt_pkg::*;

    localparam int DEPTH     = 2 * TABLE_ENTRIES;
    localparam int AW        = $clog2(DEPTH);
    localparam int EW        = $clog2(ENTRY_LIMIT + 1) + 1;
    localparam int RED_STEPS = $clog2(16383 / TABLE_ENTRIES + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_BONUS = 8'b0001_0000,
        S_GMUL  = 8'b0010_0000,
        S_GDIV  = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr;
    logic               r_corr_enable;
    logic [MATE_W-1:0]  r_mate_bound;
    t_item              r_item;
    logic [AW-1:0]      r_pa, r_wa, r_ba;
    logic               r_m_tvalid;
    logic [31:0]        r_m_tdata;

    t_item              in_item;
    logic [AW-1:0]      in_pa, in_wa, in_ba;
    logic               accept;
    logic               leave;
    t_step              step;
    t_result            result;
    logic               apply;
    logic [EW-1:0]      pawn_rd, white_rd, black_rd;
    logic [EW-1:0]      pawn_new, white_new, black_new;
    logic               we;
    logic [AW-1:0]      wa_p, wa_w, wa_b;
    logic [EW-1:0]      wd_p, wd_w, wd_b;

    // Reduce a hash index into the table by shifted compare and subtract
    function automatic logic [AW-1:0] f_addr(input logic s, input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        r = idx;
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if ({1'b0, r} >= (IDX_W+1)'(TABLE_ENTRIES * (2 ** k))) begin
                r = r - IDX_W'(TABLE_ENTRIES * (2 ** k));
            end
        end
        return AW'(r) + (s ? AW'(TABLE_ENTRIES) : AW'(0));
    endfunction

    assign in_item.op              = i_s_tuser[0];
    assign in_item.raw_eval        = $signed(i_s_tdata[58:43]);
    assign in_item.static_eval     = $signed(i_s_tdata[74:59]);
    assign in_item.best_value      = $signed(i_s_tdata[90:75]);
    assign in_item.search_depth    = i_s_tdata[98:91];
    assign in_item.has_best_move   = i_s_tdata[99];
    assign in_item.best_is_capture = i_s_tdata[100];

    assign in_pa = f_addr(i_s_tdata[0], i_s_tdata[14:1]);
    assign in_wa = f_addr(i_s_tdata[0], i_s_tdata[28:15]);
    assign in_ba = f_addr(i_s_tdata[0], i_s_tdata[42:29]);

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign leave      = (r_state == S_WB) && (!r_m_tvalid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_MUL;
            end
            S_MUL:   n_state = S_DIV;
            S_DIV: begin
                n_state = (r_item.op == OP_CORRECT) ? S_WB : S_BONUS;
            end
            S_BONUS: n_state = S_GMUL;
            S_GMUL:  n_state = S_GDIV;
            S_GDIV:  n_state = S_WB;
            S_WB: begin
                if (leave) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_enable <= ENABLE_RESET;
            r_mate_bound  <= MATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLE: r_corr_enable <= i_cfg_wdata[0];
                CFG_MATE:   r_mate_bound  <= i_cfg_wdata[MATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the item and its table addresses until write-back
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
            r_pa   <= in_pa;
            r_wa   <= in_wa;
            r_ba   <= in_ba;
        end
    end

    assign step.mul   = (r_state == S_MUL);
    assign step.div   = (r_state == S_DIV);
    assign step.bonus = (r_state == S_BONUS);
    assign step.gmul  = (r_state == S_GMUL);
    assign step.gdiv  = (r_state == S_GDIV);

    // Zero the tables during the clearing pass, otherwise write back once on leaving
    assign we   = (r_state == S_CLEAR) || (leave && apply);
    assign wa_p = (r_state == S_CLEAR) ? r_clr_addr : r_pa;
    assign wa_w = (r_state == S_CLEAR) ? r_clr_addr : r_wa;
    assign wa_b = (r_state == S_CLEAR) ? r_clr_addr : r_ba;
    assign wd_p = (r_state == S_CLEAR) ? '0 : pawn_new;
    assign wd_w = (r_state == S_CLEAR) ? '0 : white_new;
    assign wd_b = (r_state == S_CLEAR) ? '0 : black_new;

    echt_ram #(.DEPTH(DEPTH), .DW(EW)) u_pawn_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wa_p),
        .i_wdata (wd_p),
        .i_re    (accept),
        .i_raddr (in_pa),
        .o_rdata (pawn_rd)
    );

    echt_ram #(.DEPTH(DEPTH), .DW(EW)) u_white_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wa_w),
        .i_wdata (wd_w),
        .i_re    (accept),
        .i_raddr (in_wa),
        .o_rdata (white_rd)
    );

    echt_ram #(.DEPTH(DEPTH), .DW(EW)) u_black_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wa_b),
        .i_wdata (wd_b),
        .i_re    (accept),
        .i_raddr (in_ba),
        .o_rdata (black_rd)
    );

    echt_calc #(.ENTRY_LIMIT(ENTRY_LIMIT)) u_calc (
        .i_clk         (i_clk),
        .i_step        (step),
        .i_item        (r_item),
        .i_corr_enable (r_corr_enable),
        .i_mate_bound  (r_mate_bound),
        .i_pawn_rd     (pawn_rd),
        .i_white_rd    (white_rd),
        .i_black_rd    (black_rd),
        .o_result      (result),
        .o_apply       (apply),
        .o_pawn_new    (pawn_new),
        .o_white_new   (white_new),
        .o_black_new   (black_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (leave) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave) begin
            r_m_tdata <= {5'd0, result.update_applied, result.correction_term,
                          result.eval_out};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

`default_nettype wire
